// ===== design/svt_pkg.sv =====
// sorted value table package: table depth, derived widths, command and status codes
// and the result word type shared by the core and the top level
// no dependencies
package svt_pkg;

	localparam int DEPTH   = 256;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int POS_W   = 8;
	localparam int CAP_W   = 9;
	localparam int STAT_W  = 2;
	localparam int CMD_W   = 2;
	localparam int ECNT_W  = 9;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// register byte offsets, decoded on paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_FIND   = 2'd3
	} svt_cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_MISSING = 2'd3
	} svt_status_t;

	typedef struct packed {
		svt_status_t         status;
		logic [DATA_W-1:0]   read_value;
		logic [POS_W-1:0]    found_index;
		logic [ECNT_W-1:0]   entry_count;
	} svt_result_t;

endpackage

// ===== design/sorted_value_table_top.sv =====
// sorted value table top level: apb capacity register, limit and port wiring
// depends on svt_pkg and svt_core
//
// keeps up to DEPTH unsigned 32-bit words in ascending order in one single-port
// table memory with a registered read. a command word is taken when start is high
// and busy is low; busy then stays high until the result word (a rejected command
// never raises it), which sits on status, read_value, found_index and entry_count
// for exactly one cycle with done high. the receiver cannot stall, so sample the
// result on the done cycle.
// rejected commands (table full, index out of range) are answered from idle;
// read waits for the registered memory read; insert walks down from the end,
// moving each entry not less than the value up one place, then writes the word;
// remove moves each entry above the position down one place; find compares
// entries from index 0 and stops at the first entry not less than the value, or
// when it runs past the last entry. each step is a memory read followed by the
// shared compare.
// the table holds no reset contents; only entries below the count are read.
// capacity (byte address 0) limits inserts to min(capacity, DEPTH); write it only
// while busy is low and no result is pending.
module sorted_value_table_top
	import svt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// command word
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [DATA_W-1:0]    value,
	input  logic [POS_W-1:0]     position,
	// result word
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [DATA_W-1:0]    read_value,
	output logic [POS_W-1:0]     found_index,
	output logic [ECNT_W-1:0]    entry_count
);

	logic [CAP_W-1:0]  capacity_q;
	logic              cfg_write;
	logic [CNT_W-1:0]  limit;
	svt_result_t       result;

	// apb: zero wait states, write lands on the access cycle
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// words beyond the register list read as zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = 32'(capacity_q);
		end
	end

	// effective insert limit is the smaller of capacity and the table depth
	always_comb begin
		if (32'(capacity_q) < DEPTH) begin
			limit = CNT_W'(capacity_q);
		end else begin
			limit = CNT_W'(DEPTH);
		end
	end

	svt_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.limit    (limit),
		.start    (start),
		.command  (svt_cmd_t'(command)),
		.value    (value),
		.position (position),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

	assign status      = result.status;
	assign read_value  = result.read_value;
	assign found_index = result.found_index;
	assign entry_count = result.entry_count;

endmodule

// ===== design/svt_core.sv =====
// sorted value table core: table memory, entry count, one shared comparator
// and the sequencer that walks the memory for each command
// depends on svt_pkg
module svt_core
	import svt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CNT_W-1:0]     limit,
	input  logic                 start,
	input  svt_cmd_t             command,
	input  logic [DATA_W-1:0]    value,
	input  logic [POS_W-1:0]     position,
	output logic                 busy,
	output logic                 done,
	output svt_result_t          result
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_INS_RD   = 8'b0000_0010,
		S_INS_CMP  = 8'b0000_0100,
		S_REM_RD   = 8'b0000_1000,
		S_REM_WR   = 8'b0001_0000,
		S_RD_WAIT  = 8'b0010_0000,
		S_FIND_RD  = 8'b0100_0000,
		S_FIND_CMP = 8'b1000_0000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   ptr_q, ptr_d;
	logic [CNT_W-1:0]   ptr_inc, ptr_dec, count_inc, count_dec;
	logic [DATA_W-1:0]  value_q;
	logic               done_q, done_d;
	svt_result_t        res_q, res_d;
	logic               accept;

	logic [DATA_W-1:0]  mem [DEPTH];
	logic [DATA_W-1:0]  mem_rdata_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
	logic [DATA_W-1:0]  mem_wdata;

	logic               rd_lt, rd_eq;

	assign accept    = start && (state_q == S_IDLE);
	assign ptr_inc   = ptr_q + CNT_W'(1);
	assign ptr_dec   = ptr_q - CNT_W'(1);
	assign count_inc = count_q + CNT_W'(1);
	assign count_dec = count_q - CNT_W'(1);

	// shared comparator: stored word against the latched value
	assign rd_lt = mem_rdata_q < value_q;
	assign rd_eq = mem_rdata_q == value_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		done_d    = 1'b0;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q[ADDR_W-1:0];
		mem_wdata = mem_rdata_q;
		mem_raddr = ptr_q[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					res_d.status      = ST_OK;
					res_d.read_value  = '0;
					res_d.found_index = '0;
					res_d.entry_count = ECNT_W'(count_q);
					unique case (command)
						CMD_INSERT: begin
							if (count_q >= limit) begin
								res_d.status = ST_FULL;
								done_d       = 1'b1;
							end else begin
								ptr_d   = count_q;
								state_d = S_INS_RD;
							end
						end
						CMD_REMOVE: begin
							if (32'(position) >= 32'(count_q)) begin
								res_d.status = ST_RANGE;
								done_d       = 1'b1;
							end else begin
								ptr_d   = CNT_W'(position);
								state_d = S_REM_RD;
							end
						end
						CMD_READ: begin
							if (32'(position) >= 32'(count_q)) begin
								res_d.status = ST_RANGE;
								done_d       = 1'b1;
							end else begin
								mem_raddr = ADDR_W'(position);
								state_d   = S_RD_WAIT;
							end
						end
						default: begin
							ptr_d   = '0;
							state_d = S_FIND_RD;
						end
					endcase
				end
			end
			S_INS_RD: begin
				if (ptr_q == '0) begin
					mem_we            = 1'b1;
					mem_waddr         = '0;
					mem_wdata         = value_q;
					count_d           = count_inc;
					res_d.found_index = '0;
					res_d.entry_count = ECNT_W'(count_inc);
					done_d            = 1'b1;
					state_d           = S_IDLE;
				end else begin
					mem_raddr = ptr_dec[ADDR_W-1:0];
					state_d   = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (!rd_lt) begin
					// entry not less than value: move it up one and keep walking down
					mem_wdata = mem_rdata_q;
					ptr_d     = ptr_dec;
					state_d   = S_INS_RD;
				end else begin
					mem_wdata         = value_q;
					count_d           = count_inc;
					res_d.found_index = POS_W'(ptr_q);
					res_d.entry_count = ECNT_W'(count_inc);
					done_d            = 1'b1;
					state_d           = S_IDLE;
				end
			end
			S_REM_RD: begin
				if (ptr_inc >= count_q) begin
					count_d           = count_dec;
					res_d.entry_count = ECNT_W'(count_dec);
					done_d            = 1'b1;
					state_d           = S_IDLE;
				end else begin
					mem_raddr = ptr_inc[ADDR_W-1:0];
					state_d   = S_REM_WR;
				end
			end
			S_REM_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q;
				ptr_d     = ptr_inc;
				state_d   = S_REM_RD;
			end
			S_RD_WAIT: begin
				res_d.read_value = mem_rdata_q;
				done_d           = 1'b1;
				state_d          = S_IDLE;
			end
			S_FIND_RD: begin
				if (ptr_q >= count_q) begin
					res_d.status = ST_MISSING;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_FIND_CMP;
				end
			end
			S_FIND_CMP: begin
				if (rd_eq) begin
					res_d.found_index = POS_W'(ptr_q);
					done_d            = 1'b1;
					state_d           = S_IDLE;
				end else if (rd_lt) begin
					ptr_d   = ptr_inc;
					state_d = S_FIND_RD;
				end else begin
					// sorted table: passed the place the value would be
					res_d.status = ST_MISSING;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
		end
		res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("entry count above table depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result word issued while sequencer still busy");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done_q || (state_q != S_IDLE)))
		else $error("accepted command neither finished nor started");

	a_count_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> done_q)
		else $error("entry count changed without a result word");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (res_q.status == ST_FULL)) |-> (count_q == $past(count_q)))
		else $error("full insert changed the entry count");
`endif

endmodule

// ===== bench/tb_sorted_value_table_top.sv =====
// testbench for the sorted value table: commands, capacity limit, full table, random mix
// depends on svt_pkg and sorted_value_table_top; carries its own table predictor
// and checks every result word against it, field by field
module tb_sorted_value_table_top;
	import svt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          HALF_PERIOD   = 5;
	localparam int unsigned MAX_LATENCY   = 2 * DEPTH + 2;
	localparam int unsigned CYCLE_LIMIT   = 3_000_000;
	localparam int unsigned RANDOM_WORDS  = 215;
	localparam int unsigned CAP_EVERY     = 72;
	localparam logic [2:0]  CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

	// clock, reset and every block input start at known values
	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [2:0]          paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic                start    = 1'b0;
	logic [CMD_W-1:0]    command  = '0;
	logic [DATA_W-1:0]   value    = '0;
	logic [POS_W-1:0]    position = '0;

	logic [31:0]         prdata;
	logic                pready;
	logic                busy;
	logic                done;
	logic [STAT_W-1:0]   status;
	logic [DATA_W-1:0]   read_value;
	logic [POS_W-1:0]    found_index;
	logic [ECNT_W-1:0]   entry_count;

	// predicted table contents, count and capacity register
	logic [DATA_W-1:0]   sorted_words [DEPTH];
	int unsigned         word_count   = 0;
	logic [CAP_W-1:0]    capacity_reg = CAP_RESET;

	// result words still owed by the block, oldest first
	svt_result_t         results_due[$];

	int unsigned         sender_idle_pct = 0;
	int unsigned         fail_count      = 0;
	int unsigned         checked_words   = 0;
	int unsigned         sent_per_cmd [4];
	int unsigned         peak_count      = 0;
	int unsigned         cap_writes      = 0;
	int unsigned         cycle_count     = 0;

	always #HALF_PERIOD clk = ~clk;

	sorted_value_table_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.value       (value),
		.position    (position),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.found_index (found_index),
		.entry_count (entry_count)
	);

	// first ten failures are shown, the rest only counted
	task automatic note_failure(string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("error: %s", what);
		end
	endtask

	// applies one command to the predicted table and returns the word it must produce
	function automatic svt_result_t apply_table_command(svt_cmd_t cmd,
			logic [DATA_W-1:0] val, logic [POS_W-1:0] pos);
		svt_result_t res;
		int unsigned limit;
		int unsigned at;
		int unsigned i;
		res.status      = ST_OK;
		res.read_value  = '0;
		res.found_index = '0;
		limit = (capacity_reg < DEPTH) ? capacity_reg : DEPTH;
		case (cmd)
			CMD_INSERT: begin
				if (word_count >= limit) begin
					res.status = ST_FULL;
				end else begin
					// lands before the first entry that is not less than the value
					at = 0;
					while (at < word_count && sorted_words[at] < val)
						at++;
					for (i = word_count; i > at; i--)
						sorted_words[i] = sorted_words[i - 1];
					sorted_words[at] = val;
					word_count++;
					res.found_index = POS_W'(at);
				end
			end
			CMD_REMOVE: begin
				if (pos >= word_count) begin
					res.status = ST_RANGE;
				end else begin
					for (i = pos; i + 1 < word_count; i++)
						sorted_words[i] = sorted_words[i + 1];
					word_count--;
				end
			end
			CMD_READ: begin
				if (pos >= word_count)
					res.status = ST_RANGE;
				else
					res.read_value = sorted_words[pos];
			end
			default: begin
				// lowest index wins when the value is stored more than once
				res.status = ST_MISSING;
				for (i = 0; i < word_count && res.status == ST_MISSING; i++) begin
					if (sorted_words[i] == val) begin
						res.status      = ST_OK;
						res.found_index = POS_W'(i);
					end
				end
			end
		endcase
		res.entry_count = ECNT_W'(word_count);
		if (word_count > peak_count)
			peak_count = word_count;
		return res;
	endfunction

	// values: often a small pool so duplicates and hits are common, some extremes
	function automatic logic [DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 4)
			return DATA_W'($urandom_range(15));
		if (r == 4) begin
			case ($urandom_range(3))
				0: return '0;
				1: return '1;
				2: return 32'h8000_0000;
				default: return 32'h7fff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	// a stored position, now and then the first one past the end
	function automatic logic [POS_W-1:0] pick_position();
		if (word_count == 0)
			return POS_W'($urandom_range(255));
		if (word_count < 256 && $urandom_range(9) == 0)
			return POS_W'(word_count);
		return POS_W'($urandom_range(word_count - 1));
	endfunction

	// a value that is in the table, or any value while it is empty
	function automatic logic [DATA_W-1:0] pick_stored();
		if (word_count == 0)
			return pick_value();
		return sorted_words[$urandom_range(word_count - 1)];
	endfunction

	// offers one command word, holds it until the block takes it, then books the result
	task automatic send_word(svt_cmd_t cmd, logic [DATA_W-1:0] val, logic [POS_W-1:0] pos);
		svt_result_t res;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		command  <= cmd;
		value    <= val;
		position <= pos;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		res = apply_table_command(cmd, val, pos);
		results_due.push_back(res);
		sent_per_cmd[cmd]++;
	endtask

	// drops start and waits until every owed word has come back
	task automatic wait_quiet();
		start <= 1'b0;
		while (results_due.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// apb write of the capacity register, then a read back of it
	task automatic set_capacity(logic [CAP_W-1:0] cap);
		logic [31:0] got;
		wait_quiet();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= 32'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		capacity_reg = cap;
		cap_writes++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== 32'(cap))
			note_failure($sformatf("capacity read back %h, wrote %h", got, cap));
	endtask

	// every command on an empty table, then duplicates, extremes and bad positions
	task automatic test_basic_commands();
		send_word(CMD_READ,   32'h0,         8'd0);
		send_word(CMD_REMOVE, 32'h0,         8'd0);
		send_word(CMD_FIND,   32'h0,         8'd0);
		send_word(CMD_INSERT, 32'hffff_ffff, 8'd255);
		send_word(CMD_INSERT, 32'h0,         8'd0);
		send_word(CMD_INSERT, 32'h0,         8'd0);
		send_word(CMD_INSERT, 32'h8000_0000, 8'd0);
		send_word(CMD_INSERT, 32'h1,         8'd0);
		send_word(CMD_FIND,   32'h0,         8'd0);
		send_word(CMD_FIND,   32'h1234_5678, 8'd0);
		send_word(CMD_READ,   32'h0,         8'd0);
		send_word(CMD_READ,   32'h0,         8'd4);
		send_word(CMD_READ,   32'h0,         8'd5);
		send_word(CMD_READ,   32'hffff_ffff, 8'd255);
		send_word(CMD_REMOVE, 32'h0,         8'd255);
		send_word(CMD_REMOVE, 32'h0,         8'd2);
		send_word(CMD_FIND,   32'hffff_ffff, 8'd0);
	endtask

	// capacity below the count, capacity zero and the smallest real capacity
	task automatic test_capacity_limits();
		set_capacity(CAP_W'(2));
		send_word(CMD_INSERT, 32'h5, 8'd0);
		send_word(CMD_REMOVE, 32'h0, 8'd3);
		send_word(CMD_INSERT, 32'h5, 8'd0);
		send_word(CMD_REMOVE, 32'h0, 8'd0);
		send_word(CMD_INSERT, 32'h5, 8'd0);
		set_capacity(CAP_W'(0));
		send_word(CMD_INSERT, 32'h0, 8'd0);
		set_capacity(CAP_W'(1));
		send_word(CMD_INSERT, 32'h7, 8'd0);
		send_word(CMD_REMOVE, 32'h0, 8'd0);
		send_word(CMD_REMOVE, 32'h0, 8'd0);
		send_word(CMD_REMOVE, 32'h0, 8'd0);
	endtask

	// fills every entry, overflows it at two capacity settings, then drains it to 32 entries
	task automatic test_full_table();
		set_capacity(CAP_W'(DEPTH));
		while (word_count < DEPTH)
			send_word(CMD_INSERT, pick_value(), POS_W'($urandom_range(255)));
		send_word(CMD_INSERT, pick_value(), 8'd0);
		set_capacity(CAP_W'(9'h1ff));
		send_word(CMD_INSERT, 32'h0, 8'd0);
		send_word(CMD_READ, 32'h0, 8'd255);
		send_word(CMD_FIND, sorted_words[DEPTH - 1], 8'd0);
		send_word(CMD_REMOVE, 32'h0, 8'd255);
		send_word(CMD_INSERT, 32'hffff_ffff, 8'd0);
		send_word(CMD_READ, 32'h0, 8'd255);
		while (word_count > 32)
			send_word(CMD_REMOVE, $urandom(), POS_W'($urandom_range(word_count - 1)));
	endtask

	// mostly well-formed commands on the live table, a little noise, capacity moved often
	task automatic run_random_phase(int unsigned idle_pct);
		int unsigned k;
		int unsigned r;
		int unsigned ins_w;
		logic [CAP_W-1:0] cap;
		sender_idle_pct = idle_pct;
		for (k = 0; k < RANDOM_WORDS; k++) begin
			if (k % CAP_EVERY == 0) begin
				case ($urandom_range(4))
					0: cap = CAP_W'(1);
					1: cap = CAP_W'(2);
					2: cap = CAP_W'($urandom_range(24, 3));
					3: cap = CAP_W'($urandom_range(255, 25));
					default: cap = CAP_W'(DEPTH);
				endcase
				set_capacity(cap);
			end
			// keep the table from growing without end so commands stay short
			ins_w = (word_count > 96) ? 15 : 40;
			r = $urandom_range(99);
			if (r < 8)
				send_word(svt_cmd_t'($urandom_range(3)), $urandom(),
					POS_W'($urandom_range(255)));
			else if (r < 8 + ins_w)
				send_word(CMD_INSERT, pick_value(), POS_W'($urandom_range(255)));
			else if (r < 30 + ins_w)
				send_word(CMD_REMOVE, $urandom(), pick_position());
			else if (r < 45 + ins_w)
				send_word(CMD_READ, $urandom(), pick_position());
			else if ($urandom_range(1) == 0)
				send_word(CMD_FIND, pick_stored(), POS_W'($urandom_range(255)));
			else
				send_word(CMD_FIND, pick_value(), POS_W'($urandom_range(255)));
		end
	endtask

	// each done cycle carries one result word: compare it with the oldest one owed
	always @(posedge clk) begin
		svt_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (results_due.size() == 0) begin
				note_failure($sformatf("result word with none owed: status %0d count %0d",
					status, entry_count));
			end else begin
				want = results_due.pop_front();
				checked_words++;
				if (status !== want.status || read_value !== want.read_value ||
						found_index !== want.found_index ||
						entry_count !== want.entry_count)
					note_failure($sformatf({"word %0d want/got: status %0d/%0d ",
						"read_value %h/%h found_index %0d/%0d entry_count %0d/%0d"},
						checked_words, want.status, status, want.read_value, read_value,
						want.found_index, found_index, want.entry_count, entry_count));
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed",
				cycle_count, results_due.size());
			$display("tb_sorted_value_table_top NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part and the full table with the sender idling a third of the time
		sender_idle_pct = 34;
		test_basic_commands();
		test_capacity_limits();
		test_full_table();

		// random mix: sender idles a third of the time, then often, then never
		run_random_phase(34);
		run_random_phase(71);
		run_random_phase(0);

		// let the last words drain and watch for strays
		wait_quiet();
		repeat (MAX_LATENCY) @(posedge clk);

		$display("sent %0d inserts, %0d removes, %0d reads, %0d finds; %0d words checked",
			sent_per_cmd[CMD_INSERT], sent_per_cmd[CMD_REMOVE], sent_per_cmd[CMD_READ],
			sent_per_cmd[CMD_FIND], checked_words);
		$display("table peaked at %0d entries across %0d capacity writes, %0d failures",
			peak_count, cap_writes, fail_count);
		if (fail_count == 0 && results_due.size() == 0) begin
			$display("tb_sorted_value_table_top OK");
		end else begin
			$display("tb_sorted_value_table_top NOT OK");
		end
		$finish;
	end

endmodule
